>>> hdl/totpc_pkg.sv
// Shared types, field widths and ternary code points for the one-time pad codec.
`timescale 1ns / 1ps
`default_nettype none

package totpc_pkg;

   // Field widths of one transfer.
   localparam int MSG_W   = 16;
   localparam int PAD_W   = 16;
   localparam int CODE_W  = 2;
   localparam int CODES_W = 32;

   // Lane count of the default build.
   localparam int LANES_DEFAULT = 16;

   // Configuration port.
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic REG_DIRECTION = 1'b0;

   // Values of the direction register.
   localparam logic DIR_ENCODE = 1'b0;
   localparam logic DIR_DECODE = 1'b1;

   // Two-bit ternary code points.
   localparam logic [CODE_W-1:0] CODE_ZERO  = 2'd0;
   localparam logic [CODE_W-1:0] CODE_PLUS  = 2'd1;
   localparam logic [CODE_W-1:0] CODE_TWO   = 2'd2;
   localparam logic [CODE_W-1:0] CODE_MINUS = 2'd3;

   typedef struct packed {
      logic [MSG_W-1:0]   message_word;
      logic [PAD_W-1:0]   pad_low;
      logic [PAD_W-1:0]   pad_high;
      logic [CODES_W-1:0] coeff_codes;
      logic               last_word;
   } req_payload_type;

   typedef struct packed {
      logic [CODES_W-1:0] coeff_codes_out;
      logic [MSG_W-1:0]   message_out;
      logic               pad_error;
      logic               last_out;
   } rsp_payload_type;

   // What one lane hands to the merging stage.
   typedef struct packed {
      logic [CODE_W-1:0] code_out;
      logic              msg_bit;
      logic              err;
   } lane_out_type;

endpackage

`default_nettype wire

>>> hdl/totpc_lane.sv
// One coefficient lane: ternary encode or decode-and-check of a single position.
`timescale 1ns / 1ps
`default_nettype none

module totpc_lane (
   input  wire logic                           direction,
   input  wire logic                           msg_bit,
   input  wire logic                           u_bit,
   input  wire logic                           v_bit,
   input  wire logic [totpc_pkg::CODE_W-1:0]   code_in,
   output totpc_pkg::lane_out_type             lane_out
);
   import totpc_pkg::*;

   logic              a_bit;
   logic [CODE_W-1:0] enc_code;
   logic              dec_err;

   assign a_bit = u_bit ^ msg_bit;

   always_comb begin
      if (a_bit && !v_bit) begin
         enc_code = CODE_PLUS;
      end else if (!a_bit && v_bit) begin
         enc_code = CODE_MINUS;
      end else begin
         enc_code = CODE_ZERO;
      end
   end

   // t = v + coefficient must land in {0, 1}.
   always_comb begin
      case (code_in)
         CODE_ZERO:  dec_err = 1'b0;
         CODE_PLUS:  dec_err = v_bit;
         CODE_TWO:   dec_err = 1'b1;
         CODE_MINUS: dec_err = !v_bit;
         default:    dec_err = 1'b0;
      endcase
   end

   always_comb begin
      if (direction == DIR_DECODE) begin
         lane_out.code_out = CODE_ZERO;
         // Low bit of t is v xor the low code bit for every code point.
         lane_out.msg_bit  = v_bit ^ code_in[0] ^ u_bit;
         lane_out.err      = dec_err;
      end else begin
         lane_out.code_out = enc_code;
         lane_out.msg_bit  = 1'b0;
         lane_out.err      = 1'b0;
      end
   end

endmodule

`default_nettype wire

>>> hdl/totpc_merge.sv
// Merging stage: combines lane results, keeps the sticky error flag, buffers the output.
`timescale 1ns / 1ps
`default_nettype none

module totpc_merge #(
   parameter int NUM_LANES = totpc_pkg::LANES_DEFAULT
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          direction,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic                          req_last,
   input  wire logic [NUM_LANES-1:0]          err_vec,
   input  wire logic [NUM_LANES-1:0]          msg_vec,
   input  wire logic [2*NUM_LANES-1:0]        code_vec,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output totpc_pkg::rsp_payload_type         rsp_payload
);
   import totpc_pkg::*;

   logic            take_in;
   logic            out_free;
   logic            err_now;
   rsp_payload_type result;

   logic            error_seen_ff, error_seen_in;
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_data_ff, rsp_data_in;
   logic            skid_valid_ff, skid_valid_in;
   rsp_payload_type skid_data_ff, skid_data_in;

   assign req_stall = skid_valid_ff;
   assign take_in   = req_valid && !skid_valid_ff;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign err_now   = error_seen_ff || (|err_vec);

   always_comb begin
      result.coeff_codes_out = CODES_W'(code_vec);
      result.message_out     = MSG_W'(msg_vec);
      result.pad_error       = (direction == DIR_DECODE) ? err_now : 1'b0;
      result.last_out        = req_last;
   end

   always_comb begin
      error_seen_in = error_seen_ff;
      if (take_in && direction == DIR_DECODE) begin
         error_seen_in = req_last ? 1'b0 : err_now;
      end
   end

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (out_free) begin
         if (skid_valid_ff) begin
            rsp_valid_in  = 1'b1;
            rsp_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end else begin
            rsp_valid_in = take_in;
            rsp_data_in  = result;
         end
      end else if (take_in) begin
         skid_valid_in = 1'b1;
         skid_data_in  = result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         error_seen_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         error_seen_ff <= error_seen_in;
         rsp_valid_ff  <= rsp_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff  <= rsp_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_data_ff;

endmodule

`default_nettype wire

>>> hdl/ternary_one_time_pad_codec_core.sv
// Top level of the ternary one-time pad codec: config register, lanes and merging stage.
// An accepted transfer's result is registered in the output register or the skid stage.
// Throughput: one item per cycle while the skid stage is empty; all lanes work on an item
// at once, and the output register plus a one-entry skid stage let a new transfer in while
// a result is stalled. Reset (synchronous, active high) clears the direction register to
// encode, the sticky error flag and both output valid flags.
`timescale 1ns / 1ps
`default_nettype none

module ternary_one_time_pad_codec_core #(
   parameter int LANES = totpc_pkg::LANES_DEFAULT
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   // Input channel.
   input  wire logic                               req_valid,
   output logic                                    req_stall,
   input  wire totpc_pkg::req_payload_type         req_payload,
   // Result channel.
   output logic                                    rsp_valid,
   input  wire logic                               rsp_stall,
   output totpc_pkg::rsp_payload_type              rsp_payload,
   // Configuration port.
   input  wire logic                               psel,
   input  wire logic                               penable,
   input  wire logic                               pwrite,
   input  wire logic [totpc_pkg::CSR_ADDR_W-1:0]   paddr,
   input  wire logic [totpc_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic [totpc_pkg::CSR_DATA_W-1:0]        prdata,
   output logic                                    pready
);
   import totpc_pkg::*;

   // Only the lanes that fall on a field bit are built. Lanes past the sixteenth would
   // see zero pad, message and code bits and so could never raise an error or set a bit.
   localparam int ACT_LANES = (LANES < MSG_W) ? LANES : MSG_W;

   logic                     direction_ff, direction_in;
   logic                     reg_write;
   logic                     reg_index;
   logic [ACT_LANES-1:0]     err_vec;
   logic [ACT_LANES-1:0]     msg_vec;
   logic [2*ACT_LANES-1:0]   code_vec;

   // The configuration port has no wait states. Register i sits at byte address 4*i,
   // so the word index is the address above the byte offset.
   assign pready    = 1'b1;
   assign reg_index = paddr[2];
   assign reg_write = psel && penable && pwrite;

   always_comb begin
      direction_in = direction_ff;
      if (reg_write && reg_index == REG_DIRECTION) begin
         direction_in = pwdata[0];
      end
   end

   always_comb begin
      unique case (reg_index)
         REG_DIRECTION: prdata = CSR_DATA_W'(direction_ff);
         default:       prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         direction_ff <= DIR_ENCODE;
      end else begin
         direction_ff <= direction_in;
      end
   end

   // One lane per coefficient position. Each lane sees bit k of the three words and
   // code k of the coefficient field, and reports its code, message bit and error.
   for (genvar k = 0; k < ACT_LANES; k++) begin : g_lane
      lane_out_type lane_res;

      totpc_lane u_lane (
         .direction (direction_ff),
         .msg_bit   (req_payload.message_word[k]),
         .u_bit     (req_payload.pad_low[k]),
         .v_bit     (req_payload.pad_high[k]),
         .code_in   (req_payload.coeff_codes[2*k +: CODE_W]),
         .lane_out  (lane_res)
      );

      assign err_vec[k]                 = lane_res.err;
      assign msg_vec[k]                 = lane_res.msg_bit;
      assign code_vec[2*k +: CODE_W]    = lane_res.code_out;
   end

   // The merging stage ORs the lane errors into the sticky flag, which is cleared once a
   // decode transfer marked last has taken it, and registers the packed result.
   totpc_merge #(
      .NUM_LANES (ACT_LANES)
   ) u_merge (
      .clock       (clock),
      .reset       (reset),
      .direction   (direction_ff),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_last    (req_payload.last_word),
      .err_vec     (err_vec),
      .msg_vec     (msg_vec),
      .code_vec    (code_vec),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule

`default_nettype wire

>>> tb/sv/tb_ternary_one_time_pad_codec_core.sv
// Self-checking testbench for the ternary one-time pad codec core.
`timescale 1ns / 1ps

module tb_ternary_one_time_pad_codec_core;
   import totpc_pkg::*;

   // Lane count of the default build and the words that make up one polynomial.
   localparam int LANE_COUNT     = LANES_DEFAULT;
   localparam int POLY_COEFFS    = 768;
   localparam int WORDS_PER_POLY = POLY_COEFFS / LANE_COUNT;

   // Register map: the direction register sits at byte address 4 * index, and the
   // next word address decodes to no register at all.
   localparam logic [CSR_ADDR_W-1:0] DIRECTION_ADDR = CSR_ADDR_W'(4 * REG_DIRECTION);
   localparam logic [CSR_ADDR_W-1:0] UNMAPPED_ADDR  = CSR_ADDR_W'(4 * (REG_DIRECTION + 1));

   localparam int RANDOM_WORDS  = 1230;
   localparam int SETTLE_CYCLES = 8;
   localparam int HOLD_CYCLES   = 200;

   logic            clock;
   logic            reset;
   logic            req_valid;
   logic            req_stall;
   req_payload_type req_payload;
   logic            rsp_valid;
   logic            rsp_stall;
   rsp_payload_type rsp_payload;
   logic            psel;
   logic            penable;
   logic            pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata;
   logic [CSR_DATA_W-1:0] prdata;
   logic            pready;

   // Predicted copy of the block's register and sticky flag.
   logic            model_direction;
   logic            model_error_seen;

   // Results still owed by the block, oldest first.
   rsp_payload_type owed_results[$];

   int              fail_count;

   // Idle controls shared between the test tasks and the two channel drivers.
   bit              req_idle_on;
   bit              rsp_idle_on;
   int              rsp_hold_request;

   ternary_one_time_pad_codec_core dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .psel        (psel),
      .penable     (penable),
      .pwrite      (pwrite),
      .paddr       (paddr),
      .pwdata      (pwdata),
      .prdata      (prdata),
      .pready      (pready)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // A hard stop well beyond the slowest correct run.
   initial begin
      #5_000_000;
      $display("ternary_one_time_pad_codec_core regression: fail");
      $finish;
   end

   // Only the first ten failures are printed; the rest are counted.
   task automatic flag_failure(input string what);
      fail_count++;
      if (fail_count <= 10) begin
         $display("%s", what);
      end
   endtask

   // Random idle length: mostly none, often short, now and then long.
   function automatic int idle_gap(input bit enabled);
      int r;
      if (!enabled) begin
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 65) begin
         return 0;
      end
      if (r < 92) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(4, 24);
   endfunction

   // Ternary coefficient per lane: bit of x minus bit of v, as 2-bit codes.
   function automatic logic [CODES_W-1:0] ternary_encode(input logic [MSG_W-1:0] x,
                                                        input logic [PAD_W-1:0] v);
      logic [CODES_W-1:0] codes;
      codes = '0;
      for (int k = 0; k < LANE_COUNT; k++) begin
         if (x[k] && !v[k]) begin
            codes[CODE_W*k +: CODE_W] = CODE_PLUS;
         end else if (!x[k] && v[k]) begin
            codes[CODE_W*k +: CODE_W] = CODE_MINUS;
         end else begin
            codes[CODE_W*k +: CODE_W] = CODE_ZERO;
         end
      end
      return codes;
   endfunction

   // Works out the result of one accepted word and advances the sticky flag.
   function automatic rsp_payload_type pad_codec_result(input req_payload_type word);
      rsp_payload_type    result;
      logic               word_error;
      logic [CODE_W-1:0]  code;
      int                 t;
      result = '0;
      result.last_out = word.last_word;
      if (model_direction == DIR_ENCODE) begin
         // Encoding leaves the sticky flag alone.
         result.coeff_codes_out = ternary_encode(word.pad_low ^ word.message_word,
                                                 word.pad_high);
      end else begin
         word_error = 1'b0;
         for (int k = 0; k < LANE_COUNT; k++) begin
            code = word.coeff_codes[CODE_W*k +: CODE_W];
            t = int'(word.pad_high[k]) + ((code == CODE_MINUS) ? -1 : int'(code));
            if (t < 0 || t > 1) begin
               word_error = 1'b1;
            end
            // The message bit uses the low bit of t even when t is out of range.
            result.message_out[k] = t[0] ^ word.pad_low[k];
         end
         if (word_error) begin
            model_error_seen = 1'b1;
         end
         result.pad_error = model_error_seen;
         if (word.last_word) begin
            model_error_seen = 1'b0;
         end
      end
      return result;
   endfunction

   function automatic req_payload_type make_word(input logic [MSG_W-1:0] msg,
                                                 input logic [PAD_W-1:0] u,
                                                 input logic [PAD_W-1:0] v,
                                                 input logic [CODES_W-1:0] codes,
                                                 input logic last);
      req_payload_type word;
      word.message_word = msg;
      word.pad_low      = u;
      word.pad_high     = v;
      word.coeff_codes  = codes;
      word.last_word    = last;
      return word;
   endfunction

   // A random word. Decode words mostly carry codes that a matching encode would
   // have produced, so the error flag stays clear; a few are corrupted.
   function automatic req_payload_type random_word(input bit decode, input logic last);
      req_payload_type word;
      int              r;
      int              lane;
      word = make_word(MSG_W'($urandom), PAD_W'($urandom), PAD_W'($urandom),
                       CODES_W'($urandom), last);
      if (decode) begin
         word.coeff_codes = ternary_encode(word.pad_low ^ word.message_word, word.pad_high);
         r = $urandom_range(0, 99);
         lane = $urandom_range(0, LANE_COUNT - 1);
         if (r < 6) begin
            word.coeff_codes = CODES_W'($urandom);
         end else if (r < 14) begin
            word.coeff_codes[CODE_W*lane +: CODE_W] = CODE_W'($urandom_range(0, 3));
         end
      end
      return word;
   endfunction

   // Offers one word, holds it until the block takes it, then records what the
   // block owes for it.
   task automatic send_word(input req_payload_type word);
      int gap;
      gap = idle_gap(req_idle_on);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= word;
      do begin
         @(posedge clock);
      end while (req_stall);
      owed_results.push_back(pad_codec_result(word));
   endtask

   // Returns the input channel to idle and waits until every owed result is in.
   task automatic drain_results();
      req_valid <= 1'b0;
      while (owed_results.size() != 0) begin
         @(posedge clock);
      end
      repeat (2) @(posedge clock);
   endtask

   // One write transfer (setup then access); a mapped register is read back.
   task automatic csr_write(input logic [CSR_ADDR_W-1:0] addr,
                            input logic [CSR_DATA_W-1:0] data);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= addr;
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      do begin
         @(posedge clock);
      end while (!pready);
      if (addr == DIRECTION_ADDR) begin
         model_direction = data[0];
      end
      psel    <= 1'b0;
      penable <= 1'b0;
      if (addr == DIRECTION_ADDR) begin
         @(posedge clock);
         psel   <= 1'b1;
         pwrite <= 1'b0;
         @(posedge clock);
         penable <= 1'b1;
         do begin
            @(posedge clock);
         end while (!pready);
         if (prdata !== CSR_DATA_W'(model_direction)) begin
            flag_failure($sformatf("direction read back %h, expected %h",
                                   prdata, CSR_DATA_W'(model_direction)));
         end
         psel    <= 1'b0;
         penable <= 1'b0;
      end
      @(posedge clock);
   endtask

   // Encode straight out of reset: the direction register must start at encode.
   task automatic test_encode_extremes();
      req_idle_on = 1'b0;
      send_word(make_word('0, '0, '0, '0, 1'b0));
      send_word(make_word('1, '0, '0, '0, 1'b0));
      send_word(make_word('0, '0, '1, '0, 1'b0));
      send_word(make_word('1, '1, '1, '1, 1'b1));
      send_word(make_word(16'h5555, '0, 16'haaaa, '0, 1'b1));
      send_word(make_word(16'ha5a5, 16'h3c3c, 16'h0ff0, '1, 1'b0));
      drain_results();
   endtask

   // Decode: in-range sums, negative sums, the code two, and clearing on last.
   task automatic test_decode_cases();
      csr_write(DIRECTION_ADDR, CSR_DATA_W'(DIR_DECODE));
      send_word(make_word('1, '0, '0, {16{CODE_ZERO}}, 1'b0));
      send_word(make_word('0, '1, '0, {16{CODE_PLUS}}, 1'b0));
      send_word(make_word('0, '0, '1, {16{CODE_MINUS}}, 1'b0));
      // A minus one on a zero pad bit drives the sum negative.
      send_word(make_word('0, '0, '0, {16{CODE_MINUS}}, 1'b0));
      // The flag is reported on this clean last word and cleared after it.
      send_word(make_word('0, 16'h1234, '0, {16{CODE_ZERO}}, 1'b1));
      send_word(make_word('0, '0, '0, {16{CODE_ZERO}}, 1'b0));
      send_word(make_word('0, '0, '0, {CODE_TWO, {15{CODE_ZERO}}}, 1'b1));
      send_word(make_word('0, 16'hf0f0, '1, {16{CODE_TWO}}, 1'b1));
      send_word(make_word('0, '0, '1, {16{CODE_PLUS}}, 1'b1));
      drain_results();
   endtask

   // The sticky flag survives a switch to encode and back; a write to an
   // unmapped address must not touch the direction register.
   task automatic test_direction_switch();
      send_word(make_word('0, '0, '0, {CODE_ZERO, {15{CODE_TWO}}}, 1'b0));
      drain_results();
      csr_write(DIRECTION_ADDR, CSR_DATA_W'(DIR_ENCODE));
      send_word(make_word(16'hffff, 16'h00ff, 16'h0f0f, '0, 1'b1));
      drain_results();
      csr_write(UNMAPPED_ADDR, CSR_DATA_W'(DIR_DECODE));
      send_word(make_word(16'h8001, '0, 16'h7ffe, '0, 1'b0));
      drain_results();
      csr_write(DIRECTION_ADDR, CSR_DATA_W'(DIR_DECODE));
      send_word(make_word('0, '0, '0, {16{CODE_ZERO}}, 1'b1));
      send_word(make_word('0, '0, '0, {16{CODE_ZERO}}, 1'b1));
      drain_results();
   endtask

   // The receiver holds off for a long stretch while the sender keeps offering
   // back-to-back words, so the block fills and stalls its input.
   task automatic test_backpressure();
      req_idle_on = 1'b0;
      rsp_hold_request = HOLD_CYCLES;
      for (int w = 0; w < 30; w++) begin
         send_word(random_word(1'b1, w == 29));
      end
      drain_results();
   endtask

   // Phases of whole polynomials in a random direction, with some stray words
   // whose last flag is random, under varying idle patterns on both sides.
   task automatic test_random_traffic(input int target);
      int sent;
      int words;
      bit decode;
      sent = 0;
      while (sent < target) begin
         decode = 1'($urandom_range(0, 1));
         drain_results();
         csr_write(DIRECTION_ADDR, CSR_DATA_W'(decode ? DIR_DECODE : DIR_ENCODE));
         req_idle_on = ($urandom_range(0, 3) != 0);
         rsp_idle_on = ($urandom_range(0, 3) != 0);
         repeat ($urandom_range(1, 4)) begin
            words = ($urandom_range(0, 7) == 0) ? WORDS_PER_POLY
                                                : $urandom_range(1, WORDS_PER_POLY);
            for (int w = 0; w < words; w++) begin
               send_word(random_word(decode, w == words - 1));
               sent++;
            end
            if ($urandom_range(0, 9) == 0) begin
               send_word(random_word(decode, 1'($urandom_range(0, 1))));
               sent++;
            end
         end
      end
      drain_results();
   endtask

   // Receiver: stalls in random runs, or for one long counted hold when asked.
   initial begin : result_receiver
      int run;
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_hold_request > 0) begin
            rsp_stall <= 1'b1;
            repeat (rsp_hold_request) @(posedge clock);
            rsp_hold_request = 0;
            rsp_stall <= 1'b0;
         end else begin
            run = idle_gap(rsp_idle_on);
            rsp_stall <= (run > 0);
            if (run > 1) begin
               repeat (run - 1) @(posedge clock);
            end
         end
      end
   end

   // Checks every result transfer against the oldest owed result.
   initial begin : result_checker
      rsp_payload_type want;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) begin
            if (owed_results.size() == 0) begin
               flag_failure($sformatf("unexpected result codes=%h msg=%h err=%b last=%b",
                                      rsp_payload.coeff_codes_out, rsp_payload.message_out,
                                      rsp_payload.pad_error, rsp_payload.last_out));
            end else begin
               want = owed_results.pop_front();
               if (rsp_payload.coeff_codes_out !== want.coeff_codes_out ||
                   rsp_payload.message_out !== want.message_out ||
                   rsp_payload.pad_error !== want.pad_error ||
                   rsp_payload.last_out !== want.last_out) begin
                  flag_failure({
                     $sformatf("result mismatch: expected codes=%h msg=%h err=%b last=%b",
                               want.coeff_codes_out, want.message_out, want.pad_error,
                               want.last_out),
                     $sformatf(", got codes=%h msg=%h err=%b last=%b",
                               rsp_payload.coeff_codes_out, rsp_payload.message_out,
                               rsp_payload.pad_error, rsp_payload.last_out)});
               end
            end
         end
      end
   end

   // Main sequence: reset once, then each test in turn, then the verdict.
   initial begin
      fail_count       = 0;
      model_direction  = DIR_ENCODE;
      model_error_seen = 1'b0;
      req_idle_on      = 1'b0;
      rsp_idle_on      = 1'b0;
      rsp_hold_request = 0;
      reset       <= 1'b1;
      req_valid   <= 1'b0;
      req_payload <= '0;
      psel        <= 1'b0;
      penable     <= 1'b0;
      pwrite      <= 1'b0;
      paddr       <= '0;
      pwdata      <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_encode_extremes();
      test_decode_cases();
      test_direction_switch();
      test_backpressure();
      test_random_traffic(RANDOM_WORDS);

      // Give the block time to show any stray result before the verdict.
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("ternary_one_time_pad_codec_core regression: pass");
      end else begin
         $display("ternary_one_time_pad_codec_core regression: fail");
      end
      $finish;
   end

endmodule
